// ===== hdl/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, constants and helpers of the round-robin task slot scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int USED_CW   = $clog2(NUM_SLOTS + 1);

  localparam int KIND_W    = 2;
  localparam int WORD_W    = 32;
  localparam int QUERY_W   = 8;
  localparam int INDEX_W   = 6;
  localparam int STATUS_W  = 2;
  localparam int USED_W    = 7;

  localparam logic [KIND_W-1:0] KIND_SPAWN    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [STATUS_W-1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_DONE    = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPAWN,
    S_DISP,
    S_QUERY
  } fsm_t;

  // write request into the slot table, applied at the scan pointer
  typedef struct packed {
    logic              st_we;
    slot_st_t          st;
    logic              data_we;
    logic [WORD_W-1:0] entry;
    logic [WORD_W-1:0] ctx;
  } tbl_wr_t;

  // command to the scan unit
  typedef struct packed {
    logic  load;
    logic  step;
    logic  spawn_mode;
    slot_t start;
  } scan_cmd_t;

  // status from the scan unit
  typedef struct packed {
    slot_t ptr;
    logic  hit;
    logic  last;
  } scan_stat_t;

  function automatic slot_t next_slot(input slot_t s);
    next_slot = (s == slot_t'(NUM_SLOTS - 1)) ? '0 : slot_t'(s + 1'b1);
  endfunction

endpackage

// ===== hdl/rrts_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_slot_table
// Slot state, entry handle and context storage, one read/write port.
// ----------------------------------------------------------------------------
module rrts_slot_table
  import rrts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  slot_t             addr,
  input  tbl_wr_t           wr,
  output slot_st_t          rd_state,
  output logic [WORD_W-1:0] rd_entry,
  output logic [WORD_W-1:0] rd_ctx
);

  slot_st_t          state_r [NUM_SLOTS];
  logic [WORD_W-1:0] entry_r [NUM_SLOTS];
  logic [WORD_W-1:0] ctx_r   [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        state_r[i] <= SLOT_FREE;
      end
    end else if (wr.st_we) begin
      state_r[addr] <= wr.st;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.data_we) begin
      entry_r[addr] <= wr.entry;
      ctx_r[addr]   <= wr.ctx;
    end
  end

  assign rd_state = state_r[addr];
  assign rd_entry = entry_r[addr];
  assign rd_ctx   = ctx_r[addr];

endmodule

// ===== hdl/rrts_scan_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_scan_unit
// Wrapping slot pointer, step counter and the shared slot state compare.
// ----------------------------------------------------------------------------
module rrts_scan_unit
  import rrts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scan_cmd_t  cmd,
  input  slot_st_t   cur_state,
  output scan_stat_t stat
);

  slot_t ptr_r, ptr_nxt;
  slot_t cnt_r, cnt_nxt;

  always_comb begin
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      ptr_nxt = cmd.start;
      cnt_nxt = '0;
    end else if (cmd.step) begin
      ptr_nxt = next_slot(ptr_r);
      cnt_nxt = slot_t'(cnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.ptr  = ptr_r;
  // spawn takes a free or done slot, dispatch a ready one
  assign stat.hit  = cmd.spawn_mode ? (cur_state == SLOT_FREE || cur_state == SLOT_DONE)
                                    : (cur_state == SLOT_READY);
  assign stat.last = (cnt_r == slot_t'(NUM_SLOTS - 1));

endmodule

// ===== hdl/round_robin_task_slot_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_slot_scheduler_top
// Task slot table with lowest-slot spawn, round-robin dispatch and query.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in_*      input      in_valid / in_ready    kind, entry_handle, context_word,
//                                             slot_query
// out_*     output     out_valid / out_ready  ok, slot_index, task_entry,
//                                             task_context, slot_status,
//                                             used_count
//
// One transaction at a time; in_ready is low from acceptance until the result
// is taken. Spawn and dispatch walk the table one slot a cycle through the
// scan unit. Query reads the slot in S_QUERY; a refused spawn (zero handle)
// and an unused kind load the result directly. The result then waits in
// the output register until out_ready. Synchronous reset frees all slots.
// ----------------------------------------------------------------------------
module round_robin_task_slot_scheduler_top
  import rrts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [WORD_W-1:0]   in_entry_handle,
  input  logic [WORD_W-1:0]   in_context_word,
  input  logic [QUERY_W-1:0]  in_slot_query,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_ok,
  output logic [INDEX_W-1:0]  out_slot_index,
  output logic [WORD_W-1:0]   out_task_entry,
  output logic [WORD_W-1:0]   out_task_context,
  output logic [STATUS_W-1:0] out_slot_status,
  output logic [USED_W-1:0]   out_used_count
);

  fsm_t               state_r, state_nxt;
  slot_t              last_r, last_nxt;
  logic [USED_CW-1:0] used_r, used_nxt;
  logic [WORD_W-1:0]  hdl_r, ctx_r;
  logic               qin_range_r;

  logic               out_valid_r, out_valid_nxt;
  logic               ok_r;
  logic [INDEX_W-1:0] idx_r;
  logic [WORD_W-1:0]  ent_r, cx_r;
  slot_st_t           status_r;
  logic [USED_W-1:0]  out_used_r;

  logic               res_load, res_ok;
  logic [INDEX_W-1:0] res_idx;
  logic [WORD_W-1:0]  res_ent, res_ctx;
  slot_st_t           res_status;

  logic               accept;
  tbl_wr_t            wr;
  scan_cmd_t          cmd;
  scan_stat_t         stat;
  slot_st_t           rd_state;
  logic [WORD_W-1:0]  rd_entry, rd_ctx;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept   = in_valid && in_ready;

  rrts_slot_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .addr     (stat.ptr),
    .wr       (wr),
    .rd_state (rd_state),
    .rd_entry (rd_entry),
    .rd_ctx   (rd_ctx)
  );

  rrts_scan_unit u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cur_state (rd_state),
    .stat      (stat)
  );

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    used_nxt       = used_r;
    cmd.load       = 1'b0;
    cmd.step       = 1'b0;
    cmd.spawn_mode = (state_r == S_SPAWN);
    cmd.start      = '0;
    wr.st_we       = 1'b0;
    wr.st          = SLOT_READY;
    wr.data_we     = 1'b0;
    wr.entry       = hdl_r;
    wr.ctx         = ctx_r;
    res_load       = 1'b0;
    res_ok         = 1'b0;
    res_idx        = '0;
    res_ent        = '0;
    res_ctx        = '0;
    res_status     = SLOT_FREE;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_SPAWN: begin
              if (in_entry_handle != '0) begin
                cmd.load  = 1'b1;
                cmd.start = '0;
                state_nxt = S_SPAWN;
              end else begin
                res_load = 1'b1;
              end
            end
            KIND_DISPATCH: begin
              cmd.load  = 1'b1;
              cmd.start = next_slot(last_r);
              state_nxt = S_DISP;
            end
            KIND_QUERY: begin
              cmd.load  = 1'b1;
              cmd.start = in_slot_query[SLOT_W-1:0];
              state_nxt = S_QUERY;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_SPAWN: begin
        if (stat.hit) begin
          wr.st_we   = 1'b1;
          wr.st      = SLOT_READY;
          wr.data_we = 1'b1;
          if (rd_state == SLOT_FREE) begin
            used_nxt = USED_CW'(used_r + 1'b1);
          end
          res_load  = 1'b1;
          res_ok    = 1'b1;
          res_idx   = INDEX_W'(stat.ptr);
          state_nxt = S_IDLE;
        end else if (stat.last) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DISP: begin
        if (stat.hit) begin
          wr.st_we  = 1'b1;
          wr.st     = SLOT_DONE;
          last_nxt  = stat.ptr;
          res_load  = 1'b1;
          res_ok    = 1'b1;
          res_idx   = INDEX_W'(stat.ptr);
          res_ent   = rd_entry;
          res_ctx   = rd_ctx;
          state_nxt = S_IDLE;
        end else if (stat.last) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_QUERY: begin
        res_load   = 1'b1;
        res_status = qin_range_r ? rd_state : SLOT_FREE;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= slot_t'(NUM_SLOTS - 1);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the transaction payload for the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      hdl_r       <= in_entry_handle;
      ctx_r       <= in_context_word;
      qin_range_r <= (in_slot_query < QUERY_W'(NUM_SLOTS));
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      ok_r       <= res_ok;
      idx_r      <= res_idx;
      ent_r      <= res_ent;
      cx_r       <= res_ctx;
      status_r   <= res_status;
      out_used_r <= USED_W'(used_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = ok_r;
  assign out_slot_index   = idx_r;
  assign out_task_entry   = ent_r;
  assign out_task_context = cx_r;
  assign out_slot_status  = status_r;
  assign out_used_count   = out_used_r;

endmodule

// ===== hdl/rrts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_checker
  import rrts_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_ok,
  input logic [INDEX_W-1:0]  out_slot_index,
  input logic [WORD_W-1:0]   out_task_entry,
  input logic [WORD_W-1:0]   out_task_context,
  input logic [STATUS_W-1:0] out_slot_status,
  input logic [USED_W-1:0]   out_used_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_slot_index)
      && $stable(out_task_entry) && $stable(out_task_context)
      && $stable(out_slot_status) && $stable(out_used_count))
    else $error("result changed while stalled");

  // a failed transaction carries no slot or task
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_slot_index == '0 && out_task_entry == '0
      && out_task_context == '0)
    else $error("failed result carries payload");

  // only a query reports status, and a slot is never left running
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slot_status == SLOT_FREE || !out_ok)
      && out_slot_status != SLOT_RUNNING
      && out_used_count <= USED_W'(NUM_SLOTS))
    else $error("bad status or used count");

  // no new transaction while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while result pending");

  // an accepted transaction keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

endmodule

bind round_robin_task_slot_scheduler_top rrts_checker u_rrts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_ok           (out_ok),
  .out_slot_index   (out_slot_index),
  .out_task_entry   (out_task_entry),
  .out_task_context (out_task_context),
  .out_slot_status  (out_slot_status),
  .out_used_count   (out_used_count)
);

// ===== tb/round_robin_task_slot_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_slot_scheduler_top_tb
// Self-checking bench for the task slot scheduler. A scoreboard class keeps
// its own copy of the slot table, predicts the reply to every accepted
// request and compares each reply field by field. Directed requests cover
// refusals, a full table, slot reuse, round-robin order and range checks on
// queries; biased random requests follow, with random idling on both sides,
// a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module round_robin_task_slot_scheduler_top_tb;
  import rrts_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 9;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYC    = 300;
  localparam int DRAIN_CYC   = 2 * NUM_SLOTS + 8;
  localparam int SEGMENTS    = 16;
  localparam int SEG_ITEMS   = 100;

  typedef struct packed {
    logic                ok;
    logic [INDEX_W-1:0]  index;
    logic [WORD_W-1:0]   entry;
    logic [WORD_W-1:0]   ctx;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   used;
  } reply_t;

  // Slot table predictor plus the queue of replies it still owes.
  class slot_table_scoreboard;
    slot_st_t          slot_st[NUM_SLOTS];
    logic [WORD_W-1:0] slot_entry[NUM_SLOTS];
    logic [WORD_W-1:0] slot_ctx[NUM_SLOTS];
    slot_t             last_disp;
    reply_t            owed_replies[$];
    int n_errors, n_checked;
    int n_spawn_ok, n_spawn_refused, n_table_full;
    int n_disp_ok, n_disp_empty, n_query, n_unused;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_st[i]    = SLOT_FREE;
        slot_entry[i] = '0;
        slot_ctx[i]   = '0;
      end
      last_disp = slot_t'(NUM_SLOTS - 1);
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] handle,
                               logic [WORD_W-1:0] ctx_w, logic [QUERY_W-1:0] query);
      reply_t r;
      slot_t  pos;
      int     used;
      r = '0;
      case (kind)
        KIND_SPAWN: begin
          if (handle != '0) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (slot_st[i] == SLOT_FREE || slot_st[i] == SLOT_DONE) begin
                slot_st[i]    = SLOT_READY;
                slot_entry[i] = handle;
                slot_ctx[i]   = ctx_w;
                r.ok          = 1'b1;
                r.index       = INDEX_W'(i);
                break;
              end
            end
            if (!r.ok) n_table_full++;
          end
          if (r.ok) n_spawn_ok++;
          else n_spawn_refused++;
        end
        KIND_DISPATCH: begin
          pos = last_disp;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            pos = (pos == slot_t'(NUM_SLOTS - 1)) ? '0 : slot_t'(pos + 1'b1);
            if (slot_st[pos] == SLOT_READY) begin
              slot_st[pos] = SLOT_DONE;
              last_disp    = pos;
              r.ok         = 1'b1;
              r.index      = INDEX_W'(pos);
              r.entry      = slot_entry[pos];
              r.ctx        = slot_ctx[pos];
              break;
            end
          end
          if (r.ok) n_disp_ok++;
          else n_disp_empty++;
        end
        KIND_QUERY: begin
          // out-of-range index reads as free
          if (query < NUM_SLOTS) r.status = slot_st[query];
          n_query++;
        end
        default: n_unused++;
      endcase
      used = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
        if (slot_st[i] != SLOT_FREE) used++;
      r.used = USED_W'(used);
      owed_replies.push_back(r);
    endfunction

    function void compare_field(string field, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        n_errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (owed_replies.size() == 0) begin
        $error("reply with no request outstanding");
        n_errors++;
        return;
      end
      want = owed_replies.pop_front();
      n_checked++;
      compare_field("ok", WORD_W'(want.ok), WORD_W'(got.ok));
      compare_field("slot_index", WORD_W'(want.index), WORD_W'(got.index));
      compare_field("task_entry", want.entry, got.entry);
      compare_field("task_context", want.ctx, got.ctx);
      compare_field("slot_status", WORD_W'(want.status), WORD_W'(got.status));
      compare_field("used_count", WORD_W'(want.used), WORD_W'(got.used));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [WORD_W-1:0]   in_entry_handle = '0;
  logic [WORD_W-1:0]   in_context_word = '0;
  logic [QUERY_W-1:0]  in_slot_query = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_ok;
  logic [INDEX_W-1:0]  out_slot_index;
  logic [WORD_W-1:0]   out_task_entry;
  logic [WORD_W-1:0]   out_task_context;
  logic [STATUS_W-1:0] out_slot_status;
  logic [USED_W-1:0]   out_used_count;

  slot_table_scoreboard sb = new();
  int send_idle_pct = 11;
  int recv_idle_pct = 11;
  bit hold_req = 1'b0;
  int stall_cycles = 0;

  always #CLK_HALF clk = ~clk;

  round_robin_task_slot_scheduler_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_handle  (in_entry_handle),
    .in_context_word  (in_context_word),
    .in_slot_query    (in_slot_query),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_slot_index   (out_slot_index),
    .out_task_entry   (out_task_entry),
    .out_task_context (out_task_context),
    .out_slot_status  (out_slot_status),
    .out_used_count   (out_used_count)
  );

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] handle,
                              input logic [WORD_W-1:0] ctx_w,
                              input logic [QUERY_W-1:0] query);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_entry_handle <= handle;
    in_context_word <= ctx_w;
    in_slot_query   <= query;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, handle, ctx_w, query);
  endtask

  // bias: 0 spawn-heavy, 1 dispatch-heavy, 2 balanced
  task automatic send_random(input int bias);
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  handle;
    logic [QUERY_W-1:0] query;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) kind = KIND_UNUSED;
    else if (pick < 25) kind = KIND_QUERY;
    else if (pick < (bias == 0 ? 80 : bias == 1 ? 45 : 62)) kind = KIND_SPAWN;
    else kind = KIND_DISPATCH;
    handle = ($urandom_range(15) == 0) ? '0 : WORD_W'($urandom);
    query  = ($urandom_range(3) == 0) ? QUERY_W'($urandom_range(255))
                                      : QUERY_W'($urandom_range(NUM_SLOTS + 1));
    send_request(kind, handle, WORD_W'($urandom), query);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_replies.size() != 0) @(posedge clk);
  endtask

  // Receiver: check on the edge, then choose the next ready level.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_reply({out_ok, out_slot_index, out_task_entry, out_task_context,
                        out_slot_status, out_used_count});
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: stop when nothing moves for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dispatch, refusals, full table, reuse, rotation
    send_request(KIND_DISPATCH, '0, '0, '0);
    send_request(KIND_QUERY, '0, '0, 8'd0);
    send_request(KIND_SPAWN, '0, '1, '0);
    send_request(KIND_SPAWN, '1, '0, '1);
    send_request(KIND_SPAWN, 32'd1, '1, '0);
    for (int i = 2; i < NUM_SLOTS; i++)
      send_request(KIND_SPAWN, WORD_W'($urandom) | 32'd1, WORD_W'($urandom), '0);
    send_request(KIND_SPAWN, 32'h8000_0000, 32'h1234_5678, '0);
    send_request(KIND_QUERY, '0, '0, QUERY_W'(NUM_SLOTS - 1));
    send_request(KIND_QUERY, '0, '0, QUERY_W'(NUM_SLOTS));
    send_request(KIND_QUERY, '1, '1, '1);
    send_request(KIND_DISPATCH, '0, '0, '0);
    send_request(KIND_DISPATCH, '0, '0, '0);
    send_request(KIND_QUERY, '0, '0, 8'd0);
    send_request(KIND_SPAWN, 32'hCAFE_0001, 32'hBEEF_0002, '0);
    send_request(KIND_DISPATCH, '0, '0, '0);
    send_request(KIND_UNUSED, '1, '1, '1);
    send_request(KIND_QUERY, '0, '0, 8'h80);

    // hold the receiver while requests keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_random(2);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 11;
        recv_idle_pct = 11;
      end
      if (seg == SEGMENTS / 2) wait_drained();
      for (int i = 0; i < SEG_ITEMS; i++) send_random(seg % 3);
    end

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("checked %0d replies: %0d spawns placed, %0d refused (%0d on a full table)",
             sb.n_checked, sb.n_spawn_ok, sb.n_spawn_refused, sb.n_table_full);
    $display("%0d dispatches, %0d with nothing ready, %0d queries, %0d unused-kind",
             sb.n_disp_ok, sb.n_disp_empty, sb.n_query, sb.n_unused);
    if (sb.n_errors == 0 && sb.owed_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.owed_replies.size() != 0)
        $error("%0d replies never arrived", sb.owed_replies.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rrts_pkg.sv
hdl/rrts_slot_table.sv
hdl/rrts_scan_unit.sv
hdl/round_robin_task_slot_scheduler_top.sv
hdl/rrts_checker.sv
tb/round_robin_task_slot_scheduler_top_tb.sv
